[src/spectral_field_mode_advance_defines.svh]
// Assertion macros for the spectral field mode advance RTL.
`ifndef SPECTRAL_FIELD_MODE_ADVANCE_DEFINES_SVH
`define SPECTRAL_FIELD_MODE_ADVANCE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SFMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SFMA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/sfma_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the spectral field mode advance block.
package sfma_pkg;

  localparam int GRID_CELLS = 1024;
  localparam int MODE_COUNT = GRID_CELLS / 2 + 1;
  localparam int ADDR_W     = $clog2(MODE_COUNT);
  localparam int MODE_W     = 11;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int K_W        = MODE_W + CFG_W;
  localparam int PROD_W     = 2 * CFG_W;
  localparam int MUL_W      = 2 * DATA_W;
  localparam int RND_W      = MUL_W - 16;
  localparam int SUM_W      = RND_W + 2;
  localparam int NUM_W      = DATA_W + 16;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int FLD_N      = 8;

  localparam logic [CFG_W-1:0] TIME_STEP_RST            = 31'd6554;
  localparam logic [CFG_W-1:0] WAVENUMBER_STEP_RST      = 31'd402;
  localparam logic [CFG_W-1:0] LONG_WAVENUMBER_STEP_RST = 31'd201;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP            = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVENUMBER_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_WAVENUMBER_STEP = 2'd2;

  // Field slots of one stored mode word
  localparam int F_EYR = 0;
  localparam int F_EYI = 1;
  localparam int F_EZR = 2;
  localparam int F_EZI = 3;
  localparam int F_BYR = 4;
  localparam int F_BYI = 5;
  localparam int F_BZR = 6;
  localparam int F_BZI = 7;

  typedef enum logic [1:0] {
    KIND_TRANS,
    KIND_LONG,
    KIND_ZERO,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] jyr;
    logic signed [DATA_W-1:0] jyi;
    logic signed [DATA_W-1:0] jzr;
    logic signed [DATA_W-1:0] jzi;
    logic signed [DATA_W-1:0] rho_re;
    logic signed [DATA_W-1:0] rho_im;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic [FLD_N-1:0][DATA_W-1:0] fld;
    logic [DATA_W-1:0]            elx_re;
    logic [DATA_W-1:0]            elx_im;
    logic                         err;
  } result_t;

  // Q16.16 product rounding: floor((p + 2^15) / 2^16)
  function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [MUL_W-1:0] p);
    logic signed [MUL_W-1:0] t;
    t = p + $signed(MUL_W'(32768));
    return $signed(t[MUL_W-1:16]);
  endfunction

  // Saturate a wide signed sum to 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v[SUM_W-1] && !(&v[SUM_W-2:DATA_W-1])) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (!v[SUM_W-1] && (|v[SUM_W-2:DATA_W-1])) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/spectral_field_mode_advance.sv]
`timescale 1ns / 1ps
// Top level of the spectral field mode advance block.
//
// Advances one Fourier mode of a periodic 1D electromagnetic field per item, in
// Q16.16 fixed point. The block stores complex Ey, Ez, By, Bz for modes
// 0..GRID_CELLS/2 in an on-chip memory. A transverse item (req_type 0) runs a
// leapfrog step on its mode: B by half dt, E by full dt with the current, B by
// half dt again, writes the mode back and returns the new fields. A
// longitudinal item (req_type 1) returns Ex = -i*rho/k from the charge density
// on the doubled grid and changes no state; mode 0 gives zero. An index out of
// range sets range_error with all data fields zero. Sums saturate to 32 bits.
// Items pass through a two-entry queue, so the input keeps accepting until the
// queue is full while the execution side works and while a finished item waits
// on out_stall. The execution side takes one item at a time: a transverse item
// runs its sequence of four-lane multiply and update steps; a longitudinal item
// waits on the bit-serial 48-bit divider; an out-of-range item or longitudinal
// mode 0 goes straight to the result register. After reset a clearing pass
// zeroes the mode store; in_stall stays high through it, while configuration
// writes are taken as usual. Write configuration only while the block is idle.
module spectral_field_mode_advance
  import sfma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [MODE_W-1:0]        mode_index,
  input  logic signed [DATA_W-1:0] cur_y_re,
  input  logic signed [DATA_W-1:0] cur_y_im,
  input  logic signed [DATA_W-1:0] cur_z_re,
  input  logic signed [DATA_W-1:0] cur_z_im,
  input  logic signed [DATA_W-1:0] rho_re,
  input  logic signed [DATA_W-1:0] rho_im,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [MODE_W-1:0]        out_mode,
  output logic signed [DATA_W-1:0] ey_re,
  output logic signed [DATA_W-1:0] ey_im,
  output logic signed [DATA_W-1:0] ez_re,
  output logic signed [DATA_W-1:0] ez_im,
  output logic signed [DATA_W-1:0] by_re,
  output logic signed [DATA_W-1:0] by_im,
  output logic signed [DATA_W-1:0] bz_re,
  output logic signed [DATA_W-1:0] bz_im,
  output logic signed [DATA_W-1:0] elx_re,
  output logic signed [DATA_W-1:0] elx_im,
  output logic                     range_error
);

  logic    clearing;
  logic    q_pop;
  logic    q_not_empty;
  item_t   q_head;
  result_t res;

  // Accept and classify items, hold them until the execution side is free
  sfma_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .mode_index  (mode_index),
    .cur_y_re    (cur_y_re),
    .cur_y_im    (cur_y_im),
    .cur_z_re    (cur_z_re),
    .cur_z_im    (cur_z_im),
    .rho_re      (rho_re),
    .rho_im      (rho_im),
    .clearing    (clearing),
    .q_pop       (q_pop),
    .q_not_empty (q_not_empty),
    .q_head      (q_head)
  );

  // Run the field update or the divide, drive the result register
  sfma_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .res_valid   (out_valid),
    .res_stall   (out_stall),
    .res         (res)
  );

  // Unpack the result register onto the ports
  assign out_mode    = res.mode;
  assign ey_re       = $signed(res.fld[F_EYR]);
  assign ey_im       = $signed(res.fld[F_EYI]);
  assign ez_re       = $signed(res.fld[F_EZR]);
  assign ez_im       = $signed(res.fld[F_EZI]);
  assign by_re       = $signed(res.fld[F_BYR]);
  assign by_im       = $signed(res.fld[F_BYI]);
  assign bz_re       = $signed(res.fld[F_BZR]);
  assign bz_im       = $signed(res.fld[F_BZI]);
  assign elx_re      = $signed(res.elx_re);
  assign elx_im      = $signed(res.elx_im);
  assign range_error = res.err;

endmodule

[src/sfma_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module sfma_div
  import sfma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [K_W-1:0]   denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [K_W-1:0]       dvs;
  logic [K_W-1:0]       rem;
  logic [K_W:0]         trial;
  logic                 take;

  assign trial = {rem, quot[NUM_W-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy && cnt == DIV_CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= numer;
      rem  <= '0;
      dvs  <= denom;
    end else if (busy) begin
      rem  <= take ? K_W'(trial - {1'b0, dvs}) : trial[K_W-1:0];
      quot <= {quot[NUM_W-2:0], take};
    end
  end

endmodule

[src/sfma_front.sv]
`timescale 1ns / 1ps
// Input side: accept items, classify them, and hold them in a short queue.
module sfma_front
  import sfma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [MODE_W-1:0]        mode_index,
  input  logic signed [DATA_W-1:0] cur_y_re,
  input  logic signed [DATA_W-1:0] cur_y_im,
  input  logic signed [DATA_W-1:0] cur_z_re,
  input  logic signed [DATA_W-1:0] cur_z_im,
  input  logic signed [DATA_W-1:0] rho_re,
  input  logic signed [DATA_W-1:0] rho_im,
  input  logic                     clearing,
  input  logic                     q_pop,
  output logic                     q_not_empty,
  output item_t                    q_head
);

  item_t             qbuf [QDEPTH];
  item_t             new_item;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  assign in_stall    = clearing || (count == QCNT_W'(QDEPTH));
  assign push        = in_valid && !in_stall;
  assign q_not_empty = count != '0;
  assign q_head      = qbuf[rd_ptr];

  always_comb begin
    new_item.mode   = mode_index;
    new_item.jyr    = cur_y_re;
    new_item.jyi    = cur_y_im;
    new_item.jzr    = cur_z_re;
    new_item.jzi    = cur_z_im;
    new_item.rho_re = rho_re;
    new_item.rho_im = rho_im;
    if (!req_type) begin
      new_item.kind = (mode_index >= MODE_W'(MODE_COUNT)) ? KIND_ERR : KIND_TRANS;
    end else if (mode_index > MODE_W'(GRID_CELLS)) begin
      new_item.kind = KIND_ERR;
    end else if (mode_index == '0) begin
      new_item.kind = KIND_ZERO;
    end else begin
      new_item.kind = KIND_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        qbuf[wr_ptr] <= new_item;
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(q_pop);
    end
  end

endmodule

[src/sfma_back.sv]
`timescale 1ns / 1ps
// Execution side: mode store, leapfrog sequencer, longitudinal divide and result register.
`include "spectral_field_mode_advance_defines.svh"
module sfma_back
  import sfma_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 q_not_empty,
  input  item_t                q_head,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 res_valid,
  input  logic                 res_stall,
  output result_t              res
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RD, ST_PR, ST_CF, ST_H1M, ST_H1A,
    ST_EM, ST_EA, ST_H2M, ST_H2A, ST_DS, ST_DIV, ST_OUT
  } state_t;

  state_t                       state;
  logic [CFG_W-1:0]             time_step;
  logic [CFG_W-1:0]             wavenumber_step;
  logic [CFG_W-1:0]             long_wavenumber_step;
  logic [ADDR_W-1:0]            clr_addr;
  item_t                        cur;
  logic [K_W-1:0]               k_raw;
  logic [CFG_W-1:0]             k_sat;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W:0]              half_sum;
  logic [PROD_W:0]              full_sum;
  logic [CFG_W-1:0]             ch;
  logic [CFG_W-1:0]             cf;
  logic [FLD_N-1:0][DATA_W-1:0] fld;
  logic [FLD_N-1:0][DATA_W-1:0] rdata;
  logic [FLD_N-1:0][DATA_W-1:0] mem [MODE_COUNT];
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_wa;
  logic [FLD_N-1:0][DATA_W-1:0] mem_wd;
  logic                         mem_re;
  logic signed [MUL_W-1:0]      pa [4];
  logic signed [MUL_W-1:0]      pb [4];
  logic signed [RND_W-1:0]      ra [4];
  logic signed [RND_W-1:0]      rb [4];
  logic signed [DATA_W-1:0]     ma_c;
  logic signed [DATA_W-1:0]     ma_x [4];
  logic signed [DATA_W-1:0]     dt_s;
  logic signed [DATA_W-1:0]     jv [4];
  logic [DATA_W-1:0]            elx_re;
  logic [DATA_W-1:0]            elx_im;
  logic [DATA_W-1:0]            mag_re;
  logic [DATA_W-1:0]            mag_im;
  logic [NUM_W-1:0]             numer_re;
  logic [NUM_W-1:0]             numer_im;
  logic [NUM_W-1:0]             quot_re;
  logic [NUM_W-1:0]             quot_im;
  logic                         neg_re;
  logic                         neg_im;
  logic                         div_start;
  logic                         div_done_re;
  logic                         div_done_im;
  logic                         out_free;
  logic                         push;

  function automatic logic [DATA_W-1:0] upd(input logic signed [DATA_W-1:0] e,
                                            input logic signed [RND_W-1:0]  a,
                                            input logic                     a_neg,
                                            input logic signed [RND_W-1:0]  b);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(e) + (a_neg ? -SUM_W'(a) : SUM_W'(a)) - SUM_W'(b);
    return sat32(s);
  endfunction

  function automatic logic [CFG_W-1:0] coef_sat(input logic [PROD_W:0] v);
    return (|v[PROD_W:CFG_W]) ? {CFG_W{1'b1}} : v[CFG_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] qsat(input logic [NUM_W-1:0] q, input logic neg);
    logic [DATA_W-1:0] r;
    if (neg) begin
      r = (q > NUM_W'({1'b1, {(DATA_W-1){1'b0}}})) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                   : -q[DATA_W-1:0];
    end else begin
      r = (q > NUM_W'({1'b0, {(DATA_W-1){1'b1}}})) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                   : q[DATA_W-1:0];
    end
    return r;
  endfunction

  assign clearing = state == ST_CLR;
  assign out_free = !res_valid || !res_stall;
  assign push     = (state == ST_OUT) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_not_empty;

  // Mode store: clear sweep after reset, write back on result push of a transverse item
  assign mem_we = clearing || (push && cur.kind == KIND_TRANS);
  assign mem_wa = clearing ? clr_addr : cur.mode[ADDR_W-1:0];
  assign mem_wd = clearing ? '0 : fld;
  assign mem_re = state == ST_RD;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata <= mem[cur.mode[ADDR_W-1:0]];
  end

  // Coefficients
  assign k_sat    = (|k_raw[K_W-1:CFG_W]) ? {CFG_W{1'b1}} : k_raw[CFG_W-1:0];
  assign half_sum = {1'b0, prod} + (PROD_W+1)'(65536);
  assign full_sum = {1'b0, prod} + (PROD_W+1)'(32768);

  // Product lanes: field terms share four multipliers, current terms have their own
  assign dt_s  = $signed({1'b0, time_step});
  assign jv[0] = cur.jyr;
  assign jv[1] = cur.jyi;
  assign jv[2] = cur.jzr;
  assign jv[3] = cur.jzi;

  always_comb begin
    if (state == ST_EM) begin
      ma_c    = $signed({1'b0, cf});
      ma_x[0] = $signed(fld[F_BZI]);
      ma_x[1] = $signed(fld[F_BZR]);
      ma_x[2] = $signed(fld[F_BYI]);
      ma_x[3] = $signed(fld[F_BYR]);
    end else begin
      ma_c    = $signed({1'b0, ch});
      ma_x[0] = $signed(fld[F_EZI]);
      ma_x[1] = $signed(fld[F_EZR]);
      ma_x[2] = $signed(fld[F_EYI]);
      ma_x[3] = $signed(fld[F_EYR]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pa[i] <= ma_c * ma_x[i];
      pb[i] <= dt_s * jv[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ra[i] = rnd_q16(pa[i]);
      rb[i] = rnd_q16(pb[i]);
    end
  end

  // Longitudinal operands: magnitudes and signs of the two quotients
  assign mag_re    = cur.rho_im[DATA_W-1] ? DATA_W'(-cur.rho_im) : cur.rho_im;
  assign mag_im    = cur.rho_re[DATA_W-1] ? DATA_W'(-cur.rho_re) : cur.rho_re;
  assign numer_re  = {mag_re, 16'b0};
  assign numer_im  = {mag_im, 16'b0};
  assign neg_re    = cur.rho_im[DATA_W-1];
  assign neg_im    = !cur.rho_re[DATA_W-1] && (|cur.rho_re);
  assign div_start = (state == ST_DS) && (k_raw != '0);

  sfma_div u_div_re (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer_re),
    .denom (k_raw),
    .done  (div_done_re),
    .quot  (quot_re)
  );

  sfma_div u_div_im (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer_im),
    .denom (k_raw),
    .done  (div_done_im),
    .quot  (quot_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_CLR;
      clr_addr             <= '0;
      res_valid            <= 1'b0;
      time_step            <= TIME_STEP_RST;
      wavenumber_step      <= WAVENUMBER_STEP_RST;
      long_wavenumber_step <= LONG_WAVENUMBER_STEP_RST;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_TIME_STEP:            time_step <= cfg_data;
          REG_WAVENUMBER_STEP:      wavenumber_step <= cfg_data;
          REG_LONG_WAVENUMBER_STEP: long_wavenumber_step <= cfg_data;
          default: ;
        endcase
      end

      if (push) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MODE_COUNT - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_not_empty) begin
            cur    <= q_head;
            elx_re <= '0;
            elx_im <= '0;
            state  <= (q_head.kind == KIND_TRANS || q_head.kind == KIND_LONG) ? ST_RD : ST_OUT;
          end
        end
        ST_RD: begin
          k_raw <= K_W'(cur.mode) * K_W'((cur.kind == KIND_TRANS) ? wavenumber_step
                                                                   : long_wavenumber_step);
          state <= (cur.kind == KIND_TRANS) ? ST_PR : ST_DS;
        end
        ST_PR: begin
          fld   <= rdata;
          prod  <= PROD_W'(time_step) * PROD_W'(k_sat);
          state <= ST_CF;
        end
        ST_CF: begin
          ch    <= coef_sat(half_sum >> 17);
          cf    <= coef_sat(full_sum >> 16);
          state <= ST_H1M;
        end
        ST_H1M, ST_H2M: begin
          state <= (state == ST_H1M) ? ST_H1A : ST_H2A;
        end
        ST_H1A, ST_H2A: begin
          fld[F_BYR] <= upd($signed(fld[F_BYR]), ra[0], 1'b1, '0);
          fld[F_BYI] <= upd($signed(fld[F_BYI]), ra[1], 1'b0, '0);
          fld[F_BZR] <= upd($signed(fld[F_BZR]), ra[2], 1'b0, '0);
          fld[F_BZI] <= upd($signed(fld[F_BZI]), ra[3], 1'b1, '0);
          state <= (state == ST_H1A) ? ST_EM : ST_OUT;
        end
        ST_EM: begin
          state <= ST_EA;
        end
        ST_EA: begin
          fld[F_EYR] <= upd($signed(fld[F_EYR]), ra[0], 1'b0, rb[0]);
          fld[F_EYI] <= upd($signed(fld[F_EYI]), ra[1], 1'b1, rb[1]);
          fld[F_EZR] <= upd($signed(fld[F_EZR]), ra[2], 1'b1, rb[2]);
          fld[F_EZI] <= upd($signed(fld[F_EZI]), ra[3], 1'b0, rb[3]);
          state <= ST_H2M;
        end
        ST_DS: begin
          state <= (k_raw == '0) ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          if (div_done_re && div_done_im) begin
            elx_re <= qsat(quot_re, neg_re);
            elx_im <= qsat(quot_im, neg_im);
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res.mode   <= cur.mode;
            res.fld    <= (cur.kind == KIND_TRANS) ? fld : '0;
            res.elx_re <= elx_re;
            res.elx_im <= elx_im;
            res.err    <= cur.kind == KIND_ERR;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SFMA_ASSERT_RST(a_rst_clears, rst |=> clearing, "reset did not start the clearing pass")
  `SFMA_ASSERT(a_clr_no_pop, clearing |-> !q_pop, "item taken during clearing pass")
  `SFMA_ASSERT(a_clr_len, $fell(clearing) |-> $past(clr_addr) == ADDR_W'(MODE_COUNT - 1), "clearing pass cut short")
  `SFMA_ASSERT(a_div_state, (div_done_re || div_done_im) |-> state == ST_DIV, "divide finished outside divide wait")
  `SFMA_ASSERT(a_wb_trans, (mem_we && !clearing) |-> cur.kind == KIND_TRANS, "mode store written by non-transverse item")

endmodule
